/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// Each expects signals named clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define CHECK_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger.
`define CHECK_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* hdl/wrs_pkg.sv */
package wrs_pkg;

    localparam int ID_W     = 32;
    localparam int WEIGHT_W = 16;
    localparam int RND_W    = 32;
    localparam int COUNT_W  = 4;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SET    = 2'd2;
    localparam logic [1:0] CMD_SELECT = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_REFUSED  = 2'd1;
    localparam logic [1:0] STAT_NODATA   = 2'd2;
    localparam logic [1:0] STAT_HOSTDOWN = 2'd3;

    typedef struct packed {
        logic [1:0]          command;
        logic [ID_W-1:0]     server_id;
        logic [WEIGHT_W-1:0] weight;
        logic                healthy;
        logic [ID_W-1:0]     excl_id_a;
        logic                excl_valid_a;
        logic [ID_W-1:0]     excl_id_b;
        logic                excl_valid_b;
        logic [RND_W-1:0]    random_value;
    } wrs_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    selected_id;
        logic [COUNT_W-1:0] server_count;
    } wrs_rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]     server_id;
        logic [WEIGHT_W-1:0] weight;
        logic                healthy;
    } wrs_slot_t;

endpackage

/* hdl/wrs_stream_if.sv */
interface wrs_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hdl/wrs_table.sv */
module wrs_table #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  wrs_pkg::wrs_slot_t wdata,
    input  logic [AW-1:0]     raddr,
    output wrs_pkg::wrs_slot_t rdata
);
    import wrs_pkg::*;

    wrs_slot_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/wrs_mod.sv */
`include "assert_macros.svh"

module wrs_mod #(
    parameter int TW = 19
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [wrs_pkg::RND_W-1:0] dividend,
    input  logic [TW-1:0]             divisor,
    output logic                      busy,
    output logic                      done,
    output logic [TW-1:0]             rem
);
    import wrs_pkg::*;

    localparam int CNTW = $clog2(RND_W + 1);
    localparam logic [CNTW-1:0] STEPS    = CNTW'(RND_W);
    localparam logic [CNTW-1:0] LAST_CNT = CNTW'(1);

    logic [CNTW-1:0]  cnt_reg;
    logic             done_reg;
    logic [RND_W-1:0] dq_reg;
    logic [TW-1:0]    d_reg;
    logic [TW-1:0]    rem_reg;
    logic [TW:0]      rem_sh;
    logic [TW:0]      rem_sub;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_sh  = {rem_reg, dq_reg[RND_W-1]};
    assign rem_sub = rem_sh - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == LAST_CNT);
            if (start)
            begin
                cnt_reg <= STEPS;
            end
            else if (busy)
            begin
                cnt_reg <= cnt_reg - LAST_CNT;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            d_reg   <= divisor;
            rem_reg <= '0;
        end
        else if (busy)
        begin
            dq_reg <= {dq_reg[RND_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, d_reg})
            begin
                rem_reg <= rem_sub[TW-1:0];
            end
            else
            begin
                rem_reg <= rem_sh[TW-1:0];
            end
        end
    end

    assign busy = (cnt_reg != '0);
    assign done = done_reg;
    assign rem  = rem_reg;

    `CHECK_SAME(a_start_idle, start, !busy, "wrs_mod: start while busy")
    `CHECK_NEXT(a_start_busy, start, busy, "wrs_mod: start did not launch")
    `CHECK_SAME(a_rem_range, done, (d_reg == '0) || (rem_reg < d_reg), "wrs_mod: bad remainder")

endmodule

/* hdl/weighted_random_server_select.sv */
// Sequence from accept to rsp.valid: add and set run a find scan, remove a find scan
// and a read of the last entry, select up to two scans, a serial remainder step and
// a pick scan. The one-read-port slot memory and the serial remainder keep one item
// in flight; the next is taken once the result is in the output register, which
// waits while rsp is stalled. rst_n clears count and control.
`include "assert_macros.svh"

module weighted_random_server_select #(
    parameter int MAX_SERVERS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    wrs_stream_if.sink   req,
    wrs_stream_if.source rsp
);
    import wrs_pkg::*;

    localparam int CW = $clog2(MAX_SERVERS + 1);
    localparam int IW = $clog2(MAX_SERVERS);
    localparam int TW = WEIGHT_W + IW;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SERVERS);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    // sequencer states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_FIND      = 3'd1;
    localparam logic [2:0] S_LAST_RD   = 3'd2;
    localparam logic [2:0] S_LAST_WAIT = 3'd3;
    localparam logic [2:0] S_SCAN      = 3'd4;
    localparam logic [2:0] S_MOD       = 3'd5;
    localparam logic [2:0] S_PICK      = 3'd6;
    localparam logic [2:0] S_FINISH    = 3'd7;

    logic [2:0]      state_reg, state_next;
    logic [CW-1:0]   idx_reg, idx_next;        // next slot to read
    logic            pv_reg, pv_next;          // read data arrives this cycle
    logic [IW-1:0]   pidx_reg, pidx_next;      // slot of that read data
    logic            pass_reg, pass_next;      // set: exclusion ignored
    logic [TW-1:0]   total_reg, total_next;    // running (cumulative) weight
    logic [1:0]      ncand_reg, ncand_next;    // candidates, saturating at two
    logic [ID_W-1:0] first_id_reg, first_id_next;
    logic [TW-1:0]   r_reg, r_next;
    logic [IW-1:0]   k_reg, k_next;            // slot found by the search
    logic [CW-1:0]   count_reg, count_next;
    logic [1:0]      status_reg, status_next;
    logic [ID_W-1:0] sel_id_reg, sel_id_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_load;

    wrs_req_t  req_reg;
    wrs_rsp_t  rsp_reg;

    logic            accept;
    logic            scanning;
    logic            issue;
    logic            scan_end;
    logic            hit;
    logic            excl;
    logic            qualify;
    logic [TW-1:0]   cum;
    logic [CW-1:0]   last_cnt;
    logic [CW+3:0]   count_ext;

    logic            we;
    logic [IW-1:0]   waddr;
    logic [IW-1:0]   raddr;
    wrs_slot_t       wdata;
    wrs_slot_t       rdata;

    logic            mod_start;
    logic            mod_busy;
    logic            mod_done;
    logic [TW-1:0]   mod_rem;

    wrs_table #(
        .DEPTH (MAX_SERVERS),
        .AW    (IW)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    wrs_mod #(
        .TW (TW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (req_reg.random_value),
        .divisor  (total_reg),
        .busy     (mod_busy),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign accept   = req.valid && req.ready;
    assign scanning = state_reg inside {S_FIND, S_SCAN, S_PICK};
    // read one slot a cycle while below the entry count
    assign issue    = scanning && (idx_reg < count_reg);
    assign scan_end = scanning && !issue && !pv_reg;
    assign last_cnt = count_reg - CNT_ONE;
    assign raddr    = (state_reg == S_LAST_RD) ? last_cnt[IW-1:0] : idx_reg[IW-1:0];

    assign hit     = (rdata.server_id == req_reg.server_id);
    assign excl    = (req_reg.excl_valid_a && (rdata.server_id == req_reg.excl_id_a)) ||
                     (req_reg.excl_valid_b && (rdata.server_id == req_reg.excl_id_b));
    assign qualify = rdata.healthy && (pass_reg || !excl);
    assign cum     = total_reg + TW'(rdata.weight);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg + CW'(issue);
        pv_next        = issue;
        pidx_next      = idx_reg[IW-1:0];
        pass_next      = pass_reg;
        total_next     = total_reg;
        ncand_next     = ncand_reg;
        first_id_next  = first_id_reg;
        r_next         = r_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        sel_id_next    = sel_id_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_load       = 1'b0;
        mod_start      = 1'b0;
        we             = 1'b0;
        waddr          = pidx_reg;
        wdata          = '{server_id: req_reg.server_id,
                           weight:    req_reg.weight,
                           healthy:   req_reg.healthy};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next    = '0;
                    pv_next     = 1'b0;
                    pass_next   = 1'b0;
                    total_next  = '0;
                    ncand_next  = '0;
                    sel_id_next = '0;
                    status_next = STAT_OK;
                    case (req.payload.command)
                        CMD_ADD:
                        begin
                            if (count_reg == CNT_MAX)
                            begin
                                status_next = STAT_REFUSED;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_FIND;
                            end
                        end
                        CMD_REMOVE, CMD_SET:
                        begin
                            state_next = S_FIND;
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_NODATA;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end

            S_FIND:
            begin
                if (pv_reg && hit)
                begin
                    pv_next = 1'b0;
                    k_next  = pidx_reg;
                    case (req_reg.command)
                        CMD_ADD:
                        begin
                            status_next = STAT_REFUSED;
                            state_next  = S_FINISH;
                        end
                        CMD_REMOVE:
                        begin
                            state_next = S_LAST_RD;
                        end
                        default:
                        begin
                            // set: rewrite the slot with new weight and health
                            we         = 1'b1;
                            waddr      = pidx_reg;
                            state_next = S_FINISH;
                        end
                    endcase
                end
                else if (scan_end)
                begin
                    if (req_reg.command == CMD_ADD)
                    begin
                        we         = 1'b1;
                        waddr      = count_reg[IW-1:0];
                        count_next = count_reg + CNT_ONE;
                    end
                    else
                    begin
                        status_next = STAT_REFUSED;
                    end
                    state_next = S_FINISH;
                end
            end

            S_LAST_RD:
            begin
                state_next = S_LAST_WAIT;
            end

            S_LAST_WAIT:
            begin
                // move the last entry into the freed slot
                we         = 1'b1;
                waddr      = k_reg;
                wdata      = rdata;
                count_next = last_cnt;
                state_next = S_FINISH;
            end

            S_SCAN:
            begin
                if (pv_reg && qualify)
                begin
                    total_next = cum;
                    if (ncand_reg != 2'd2)
                    begin
                        ncand_next = ncand_reg + 2'd1;
                    end
                    if (ncand_reg == 2'd0)
                    begin
                        first_id_next = rdata.server_id;
                    end
                end
                if (scan_end)
                begin
                    if ((ncand_reg == 2'd0) && !pass_reg)
                    begin
                        pass_next = 1'b1;
                        idx_next  = '0;
                    end
                    else if (ncand_reg == 2'd0)
                    begin
                        status_next = STAT_HOSTDOWN;
                        state_next  = S_FINISH;
                    end
                    else if (ncand_reg == 2'd1)
                    begin
                        sel_id_next = first_id_reg;
                        state_next  = S_FINISH;
                    end
                    else if (total_reg == '0)
                    begin
                        r_next     = '0;
                        total_next = '0;
                        idx_next   = '0;
                        state_next = S_PICK;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = S_MOD;
                    end
                end
            end

            S_MOD:
            begin
                if (mod_done)
                begin
                    r_next     = mod_rem;
                    total_next = '0;
                    idx_next   = '0;
                    state_next = S_PICK;
                end
            end

            S_PICK:
            begin
                if (pv_reg && qualify)
                begin
                    total_next = cum;
                    if (cum > r_reg)
                    begin
                        sel_id_next = rdata.server_id;
                        pv_next     = 1'b0;
                        state_next  = S_FINISH;
                    end
                end
                else if (scan_end)
                begin
                    // only when every candidate weighs nothing
                    status_next = STAT_HOSTDOWN;
                    state_next  = S_FINISH;
                end
            end

            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            pv_reg        <= 1'b0;
            pass_reg      <= 1'b0;
            ncand_reg     <= '0;
            count_reg     <= '0;
            status_reg    <= STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pv_reg        <= pv_next;
            pass_reg      <= pass_next;
            ncand_reg     <= ncand_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers carry no reset
    always_ff @(posedge clk)
    begin
        pidx_reg     <= pidx_next;
        total_reg    <= total_next;
        first_id_reg <= first_id_next;
        r_reg        <= r_next;
        k_reg        <= k_next;
        sel_id_reg   <= sel_id_next;
        if (accept)
        begin
            req_reg <= req.payload;
        end
        if (out_load)
        begin
            rsp_reg.status       <= status_reg;
            rsp_reg.selected_id  <= sel_id_reg;
            rsp_reg.server_count <= count_ext[COUNT_W-1:0];
        end
    end

    // the result field carries the low four bits of the count
    assign count_ext = {4'b0000, count_reg};

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = rsp_reg;

    `CHECK_SAME(a_count_max, 1'b1, count_reg <= CNT_MAX, "count beyond table size")
    `CHECK_SAME(a_read_live, pv_reg, CW'(pidx_reg) < count_reg, "read of a dead slot")
    `CHECK_SAME(a_mod_run, state_reg == S_MOD, mod_busy || mod_done, "remainder unit idle")
    `CHECK_SAME(a_mod_div, mod_start, total_reg != '0, "remainder by zero weight")

endmodule

/* tb/tb_weighted_random_server_select.sv */
`timescale 1ns / 100ps

module tb_weighted_random_server_select;

    import wrs_pkg::*;

    localparam int SERVER_SLOTS = 8;
    localparam int POOL_SIZE    = 12;
    // Drain wait, longer than a full-table select to allow some margin.
    localparam int DRAIN_CYCLES = 120;
    // Slowest run: ~800 transfers, each a full-table select plus long idle
    // tails on both sides, plus one long receiver hold-off; taken many times over.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;

    // Scoreboard: keeps its own copy of the server table, works out the
    // reply for every accepted command and checks replies in order.
    class server_table_tracker #(int SLOTS = 8);
        wrs_slot_t   slots [SLOTS];
        int unsigned entries;
        wrs_rsp_t    pending_replies [$];
        int unsigned mismatch_count;

        function new();
            entries        = 0;
            mismatch_count = 0;
        endfunction

        task flag_mismatch(string msg);
            $display("%0t ERROR: %s", $time, msg);
            mismatch_count++;
        endtask

        function int outstanding();
            return pending_replies.size();
        endfunction

        function int locate(logic [ID_W-1:0] id);
            for (int i = 0; i < entries; i++)
                if (slots[i].server_id == id)
                    return i;
            return SLOTS;
        endfunction

        function void apply_command(wrs_req_t item);
            wrs_rsp_t            reply;
            int                  k;
            int                  n;
            logic [ID_W-1:0]     total;
            logic [ID_W-1:0]     r;
            logic [ID_W-1:0]     cum [SLOTS];
            logic [ID_W-1:0]     cid [SLOTS];
            bit                  barred;
            reply        = '0;
            reply.status = STAT_OK;
            k            = locate(item.server_id);
            case (item.command)
                CMD_ADD:
                begin
                    if (k != SLOTS || entries >= SLOTS)
                        reply.status = STAT_REFUSED;
                    else
                    begin
                        slots[entries].server_id = item.server_id;
                        slots[entries].weight    = item.weight;
                        slots[entries].healthy   = item.healthy;
                        entries++;
                    end
                end
                CMD_REMOVE:
                begin
                    if (k == SLOTS)
                        reply.status = STAT_REFUSED;
                    else
                    begin
                        slots[k] = slots[entries - 1];
                        entries--;
                    end
                end
                CMD_SET:
                begin
                    if (k == SLOTS)
                        reply.status = STAT_REFUSED;
                    else
                    begin
                        slots[k].weight  = item.weight;
                        slots[k].healthy = item.healthy;
                    end
                end
                default:
                begin
                    if (entries == 0)
                        reply.status = STAT_NODATA;
                    else if (entries == 1)
                    begin
                        if (slots[0].healthy)
                            reply.selected_id = slots[0].server_id;
                        else
                            reply.status = STAT_HOSTDOWN;
                    end
                    else
                    begin
                        n     = 0;
                        total = '0;
                        // First pass honours the exclusions, second ignores them.
                        for (int pass = 0; pass < 2 && n == 0; pass++)
                        begin
                            total = '0;
                            for (int i = 0; i < entries; i++)
                            begin
                                barred = (item.excl_valid_a && slots[i].server_id == item.excl_id_a)
                                      || (item.excl_valid_b && slots[i].server_id == item.excl_id_b);
                                if ((pass == 0 && barred) || !slots[i].healthy)
                                    continue;
                                total  = total + ID_W'(slots[i].weight);
                                cum[n] = total;
                                cid[n] = slots[i].server_id;
                                n++;
                            end
                        end
                        if (n == 0)
                            reply.status = STAT_HOSTDOWN;
                        else if (n == 1)
                            reply.selected_id = cid[0];
                        else
                        begin
                            r = (total == 0) ? '0 : item.random_value % total;
                            reply.status = STAT_HOSTDOWN;
                            // Walk down so the lowest qualifying slot wins.
                            for (int i = n - 1; i >= 0; i--)
                                if (cum[i] > r)
                                begin
                                    reply.status      = STAT_OK;
                                    reply.selected_id = cid[i];
                                end
                        end
                    end
                end
            endcase
            reply.server_count = COUNT_W'(entries);
            pending_replies.insert(pending_replies.size(), reply);
        endfunction

        task compare_reply(wrs_rsp_t got);
            wrs_rsp_t want;
            if (pending_replies.size() == 0)
            begin
                flag_mismatch($sformatf("reply %h with none outstanding", got));
                return;
            end
            want = pending_replies.pop_front();
            if (got.status != want.status)
                flag_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
            if (got.selected_id != want.selected_id)
                flag_mismatch($sformatf("selected_id %h, wanted %h",
                                        got.selected_id, want.selected_id));
            if (got.server_count != want.server_count)
                flag_mismatch($sformatf("server_count %0d, wanted %0d",
                                        got.server_count, want.server_count));
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    wrs_stream_if #(.payload_t(wrs_req_t)) req_if ();
    wrs_stream_if #(.payload_t(wrs_rsp_t)) rsp_if ();

    weighted_random_server_select #(
        .MAX_SERVERS (SERVER_SLOTS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    server_table_tracker #(SERVER_SLOTS) tracker;

    logic [ID_W-1:0] id_pool [POOL_SIZE];
    int unsigned     src_idle_pct  = 6;
    int unsigned     sink_idle_pct = 83;
    bit              sink_hold     = 1'b0;
    int unsigned     cycle_count   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: give up if the run hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Monitor both channels at the same edge. Check the reply before noting
    // a new command so that a transfer on each side in one cycle stays ordered.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
                tracker.compare_reply(rsp_if.payload);
            if (req_if.valid && req_if.ready)
                tracker.apply_command(req_if.payload);
        end
    end

    // Receiver: drop ready at random, and hold it low throughout a hold-off.
    initial
    begin
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || sink_hold)
                rsp_if.ready <= 1'b0;
            else
                rsp_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Offer one command, idling first at random, and return at the edge where
    // the transfer happens. Valid stays high into the next command unless it idles.
    task automatic send_item(input wrs_req_t item);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= item;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    function automatic wrs_req_t make_req(
        input logic [1:0]          cmd,
        input logic [ID_W-1:0]     id,
        input logic [WEIGHT_W-1:0] w,
        input logic                h,
        input logic [ID_W-1:0]     ea  = '0,
        input logic                va  = 1'b0,
        input logic [ID_W-1:0]     eb  = '0,
        input logic                vb  = 1'b0,
        input logic [RND_W-1:0]    rnd = '0
    );
        wrs_req_t item;
        item.command      = cmd;
        item.server_id    = id;
        item.weight       = w;
        item.healthy      = h;
        item.excl_id_a    = ea;
        item.excl_valid_a = va;
        item.excl_id_b    = eb;
        item.excl_valid_b = vb;
        item.random_value = rnd;
        return item;
    endfunction

    // Random commands. Most draw ids from a small pool so the table fills,
    // empties and sees real duplicates, removals and updates; a few are pure noise.
    task automatic run_random(input int unsigned n_items);
        wrs_req_t    item;
        int unsigned pick;
        repeat (n_items)
        begin
            item.server_id    = $urandom;
            item.weight       = WEIGHT_W'($urandom_range(0, 65535));
            item.healthy      = 1'($urandom_range(0, 1));
            item.excl_id_a    = $urandom;
            item.excl_valid_a = 1'($urandom_range(0, 1));
            item.excl_id_b    = $urandom;
            item.excl_valid_b = 1'($urandom_range(0, 1));
            item.random_value = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 8)
                item.command = 2'($urandom_range(0, 3));
            else
            begin
                if (pick < 38)
                    item.command = CMD_ADD;
                else if (pick < 56)
                    item.command = CMD_REMOVE;
                else if (pick < 72)
                    item.command = CMD_SET;
                else
                    item.command = CMD_SELECT;
                item.server_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
                item.healthy   = ($urandom_range(0, 9) < 8);
                case ($urandom_range(0, 9))
                    0:       item.weight = '0;
                    1:       item.weight = '1;
                    2, 3:    item.weight = WEIGHT_W'($urandom_range(0, 65535));
                    default: item.weight = WEIGHT_W'($urandom_range(1, 20));
                endcase
                // Exclude ids that are likely in the table most of the time.
                if ($urandom_range(0, 3) != 0)
                    item.excl_id_a = id_pool[$urandom_range(0, POOL_SIZE - 1)];
                if ($urandom_range(0, 3) != 0)
                    item.excl_id_b = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            send_item(item);
        end
    endtask

    initial
    begin
        tracker        = new();
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = $urandom;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, refusals, single entry, exclusion fallback,
        // all-zero weights, full table and removal with the last slot moving up.
        send_item(make_req(CMD_SELECT, '0, '0, 1'b0));
        send_item(make_req(CMD_REMOVE, '1, '0, 1'b0));
        send_item(make_req(CMD_SET, 32'd5, 16'd7, 1'b1));
        send_item(make_req(CMD_ADD, '1, '1, 1'b0));
        send_item(make_req(CMD_SELECT, '0, '0, 1'b0));
        send_item(make_req(CMD_SET, '1, '1, 1'b1));
        send_item(make_req(CMD_SELECT, '0, '0, 1'b0, '0, 1'b0, '0, 1'b0, '1));
        send_item(make_req(CMD_ADD, '1, 16'd3, 1'b1));
        send_item(make_req(CMD_ADD, '0, '0, 1'b1));
        send_item(make_req(CMD_SELECT, '0, '0, 1'b0, '1, 1'b1));
        send_item(make_req(CMD_SELECT, '1, '1, 1'b1, '1, 1'b1, '0, 1'b1, '1));
        send_item(make_req(CMD_SET, '1, '0, 1'b1));
        send_item(make_req(CMD_SELECT, '0, '0, 1'b0, '0, 1'b0, '0, 1'b0, 32'd99));
        send_item(make_req(CMD_ADD, 32'd1, 16'd1, 1'b1));
        send_item(make_req(CMD_ADD, 32'd2, 16'd2, 1'b1));
        send_item(make_req(CMD_ADD, 32'd3, 16'd3, 1'b0));
        send_item(make_req(CMD_ADD, 32'd4, '1, 1'b1));
        send_item(make_req(CMD_ADD, 32'd5, 16'd10, 1'b1));
        send_item(make_req(CMD_ADD, 32'd6, 16'd1, 1'b1));
        send_item(make_req(CMD_ADD, 32'd7, 16'd1, 1'b1));
        send_item(make_req(CMD_SELECT, '0, '0, 1'b0, '0, 1'b0, 32'd4, 1'b0, '1));
        send_item(make_req(CMD_SELECT, '0, '0, 1'b0, 32'd4, 1'b1, 32'd2, 1'b1, '0));
        send_item(make_req(CMD_REMOVE, '0, '0, 1'b0));
        send_item(make_req(CMD_REMOVE, '0, '0, 1'b0));
        send_item(make_req(CMD_SELECT, '0, '0, 1'b0, '0, 1'b0, '0, 1'b0, 32'd12345));

        // Sender mostly busy, receiver mostly stalled.
        run_random(250);

        // Swap: sender mostly idle, receiver mostly ready.
        src_idle_pct  <= 83;
        sink_idle_pct <= 6;
        run_random(250);

        // No idling at all, with one long hold-off on the receiver so the
        // block backs up and stalls its input.
        src_idle_pct  <= 0;
        sink_idle_pct <= 0;
        run_random(60);
        fork
            begin
                sink_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold <= 1'b0;
            end
        join_none
        run_random(190);
        req_if.valid <= 1'b0;

        // Drain: wait for every reply, then let any stray one show up.
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* weighted_random_server_select.f */
+incdir+hdl
hdl/wrs_pkg.sv
hdl/wrs_stream_if.sv
hdl/wrs_table.sv
hdl/wrs_mod.sv
hdl/weighted_random_server_select.sv
tb/tb_weighted_random_server_select.sv
